[rtl/core/flux_limiter_unit_defines.svh]
// Assertion macros shared by the flux limiter unit.
`ifndef FLUX_LIMITER_UNIT_DEFINES_SVH
`define FLUX_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flux limiter check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FLU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flux limiter check failed");

`endif

[rtl/core/flu_pkg.sv]
package flu_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SEL_BITS      = 5;

  typedef enum logic [SEL_BITS-1:0] {
    LIM_DONOR    = 5'd0,
    LIM_LAXW     = 5'd1,
    LIM_BEAMW    = 5'd2,
    LIM_FROMM    = 5'd3,
    LIM_CHARM    = 5'd4,
    LIM_HCUS     = 5'd5,
    LIM_HQUICK   = 5'd6,
    LIM_KOREN    = 5'd7,
    LIM_MINMOD   = 5'd8,
    LIM_OSHER    = 5'd9,
    LIM_OSPRE    = 5'd10,
    LIM_SMART    = 5'd11,
    LIM_SWEBY    = 5'd12,
    LIM_UMIST    = 5'd13,
    LIM_VANALB1  = 5'd14,
    LIM_VANALB2  = 5'd15,
    LIM_VANLEER  = 5'd16,
    LIM_MC       = 5'd17,
    LIM_SUPERBEE = 5'd18,
    LIM_BARTH    = 5'd19
  } lim_sel_t;

  // Per-item side flags that ride along the divider.
  typedef struct packed {
    logic fault;
    logic neg;
  } flu_flags_t;

endpackage

[rtl/core/flu_front.sv]
module flu_front #(
  parameter int unsigned WORD_BITS = flu_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = flu_pkg::FRAC_BITS_DEF,
  localparam int unsigned MB = 2 * WORD_BITS + FRAC_BITS + 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [WORD_BITS-1:0] in_ratio,
  input  flu_pkg::lim_sel_t           sel,
  output logic                        out_v,
  output logic [MB-1:0]               out_num,
  output logic [MB-1:0]               out_den,
  output flu_pkg::flu_flags_t         out_flags
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned LW = W + F + 8;
  localparam int unsigned PW = 2 * W + 6;
  localparam int unsigned SW = MB + 1;

  localparam logic signed [LW-1:0] S_L =
    {{(LW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [LW-1:0] ZERO_L = '0;

  function automatic logic signed [LW-1:0] smin(input logic signed [LW-1:0] a,
                                                input logic signed [LW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [LW-1:0] smax(input logic signed [LW-1:0] a,
                                                input logic signed [LW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  // Stage A: sums that feed the multipliers.
  logic                    a_v_r;
  logic signed [W-1:0]     a_r_r;
  flu_pkg::lim_sel_t       a_sel_r;
  logic signed [W:0]       a_s1_r;
  logic signed [W+2:0]     a_s3_r;
  logic signed [LW-1:0]    in_l;
  logic signed [LW-1:0]    s1_nxt;
  logic signed [LW-1:0]    s3_nxt;

  assign in_l   = LW'(in_ratio);
  assign s1_nxt = in_l + S_L;
  assign s3_nxt = (in_l <<< 1) + in_l + S_L;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
    end
    if (en) begin
      a_r_r   <= in_ratio;
      a_sel_r <= sel;
      a_s1_r  <= s1_nxt[W:0];
      a_s3_r  <= s3_nxt[W+2:0];
    end
  end

  // Stage B: products and the piecewise-linear limiters.
  logic                    b_v_r;
  logic signed [W-1:0]     b_r_r;
  flu_pkg::lim_sel_t       b_sel_r;
  logic signed [PW-1:0]    b_pa_r, b_pb_r, b_pc_r, b_prr_r;
  logic signed [LW-1:0]    b_lin_r;
  logic signed [PW-1:0]    pa_nxt, pb_nxt, pc_nxt, prr_nxt;
  logic signed [LW-1:0]    lin_nxt;
  logic signed [LW-1:0]    r_l, t_l, r2, r3, r4, r8, r24;
  logic signed [LW-1:0]    s2, s3, s4, s8, s16, s24;

  assign pa_nxt  = PW'(a_r_r) * PW'(a_s1_r);
  assign pb_nxt  = PW'(a_r_r) * PW'(a_s3_r);
  assign pc_nxt  = PW'(a_s1_r) * PW'(a_s1_r);
  assign prr_nxt = PW'(a_r_r) * PW'(a_r_r);

  assign r_l = LW'(a_r_r);
  assign t_l = r_l + S_L;
  assign r2  = r_l <<< 1;
  assign r3  = r2 + r_l;
  assign r4  = r_l <<< 2;
  assign r8  = r_l <<< 3;
  assign r24 = (r_l <<< 4) + r8;
  assign s2  = S_L <<< 1;
  assign s3  = s2 + S_L;
  assign s4  = S_L <<< 2;
  assign s8  = S_L <<< 3;
  assign s16 = S_L <<< 4;
  assign s24 = s16 + s8;

  always_comb begin
    case (a_sel_r)
      flu_pkg::LIM_LAXW:     lin_nxt = S_L;
      flu_pkg::LIM_BEAMW:    lin_nxt = r_l;
      flu_pkg::LIM_FROMM:    lin_nxt = t_l;
      flu_pkg::LIM_KOREN:
        lin_nxt = smax(ZERO_L, smin(r24, smin((S_L + r2) <<< 2, s24)));
      flu_pkg::LIM_MINMOD:   lin_nxt = smax(ZERO_L, smin(r_l, S_L));
      flu_pkg::LIM_OSHER:    lin_nxt = smax(ZERO_L, smin(r2, s3));
      flu_pkg::LIM_SMART:
        lin_nxt = smax(ZERO_L, smin(r8, smin(S_L + r3, s16)));
      flu_pkg::LIM_SWEBY:
        lin_nxt = smax(ZERO_L, smax(smin(r3, s2), smin(r2, s3)));
      flu_pkg::LIM_UMIST:
        lin_nxt = smax(ZERO_L, smin(smin(r8, s3 + r_l), smin(S_L + r3, s8)));
      flu_pkg::LIM_MC:
        lin_nxt = smax(ZERO_L, smin(s4, smin(t_l, r4)));
      flu_pkg::LIM_SUPERBEE:
        lin_nxt = smax(ZERO_L, smax(smin(S_L, r2), smin(s2, r_l)));
      flu_pkg::LIM_BARTH:
        lin_nxt = t_l[LW-1] ? smax(t_l, smax(r4, s4)) : smin(t_l, smin(r4, s4));
      default:               lin_nxt = ZERO_L;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_r_r   <= a_r_r;
      b_sel_r <= a_sel_r;
      b_pa_r  <= pa_nxt;
      b_pb_r  <= pb_nxt;
      b_pc_r  <= pc_nxt;
      b_prr_r <= prr_nxt;
      b_lin_r <= lin_nxt;
    end
  end

  // Stage C: pick numerator and denominator, split into sign and magnitude.
  localparam logic signed [SW-1:0] S_S  = SW'(S_L);
  localparam logic signed [SW-1:0] SS_S = S_S <<< F;
  localparam logic signed [SW-1:0] D1   = SW'(1);
  localparam logic signed [SW-1:0] D2   = SW'(2);
  localparam logic signed [SW-1:0] D4   = SW'(4);
  localparam logic signed [SW-1:0] D12  = SW'(12);

  logic signed [SW-1:0] rs, pa_s, num_s, den_s, num_a, den_a;
  logic                 fault_nxt;
  logic                 r_pos;

  assign rs    = SW'(b_r_r);
  assign pa_s  = SW'(b_pa_r);
  assign r_pos = !b_r_r[W-1] && (b_r_r != '0);

  always_comb begin
    num_s     = '0;
    den_s     = D1;
    fault_nxt = 1'b0;
    case (b_sel_r)
      flu_pkg::LIM_LAXW, flu_pkg::LIM_BEAMW, flu_pkg::LIM_MINMOD,
      flu_pkg::LIM_SUPERBEE: begin
        num_s = SW'(b_lin_r);
      end
      flu_pkg::LIM_FROMM, flu_pkg::LIM_OSHER, flu_pkg::LIM_SWEBY,
      flu_pkg::LIM_MC: begin
        num_s = SW'(b_lin_r);
        den_s = D2;
      end
      flu_pkg::LIM_SMART, flu_pkg::LIM_UMIST: begin
        num_s = SW'(b_lin_r);
        den_s = D4;
      end
      flu_pkg::LIM_KOREN: begin
        num_s = SW'(b_lin_r);
        den_s = D12;
      end
      flu_pkg::LIM_CHARM: begin
        if (!b_r_r[W-1]) begin
          num_s = SW'(b_pb_r) <<< F;
          den_s = SW'(b_pc_r);
        end
      end
      flu_pkg::LIM_HCUS: begin
        if (r_pos) begin
          num_s = ((rs <<< 1) + rs) <<< F;
          den_s = rs + (S_S <<< 1);
        end else if (rs == -(S_S <<< 1)) begin
          fault_nxt = 1'b1;
        end
      end
      flu_pkg::LIM_HQUICK: begin
        if (r_pos) begin
          num_s = rs <<< (F + 2);
          den_s = rs + (S_S <<< 1) + S_S;
        end else if (rs == -((S_S <<< 1) + S_S)) begin
          fault_nxt = 1'b1;
        end
      end
      flu_pkg::LIM_OSPRE: begin
        num_s = ((pa_s <<< 2) + pa_s) <<< F;
        den_s = (pa_s <<< 3) + (pa_s <<< 1) + SS_S;
      end
      flu_pkg::LIM_VANALB1: begin
        num_s = pa_s <<< F;
        den_s = SW'(b_prr_r) + SS_S;
      end
      flu_pkg::LIM_VANALB2: begin
        num_s = rs <<< (2 * F + 1);
        den_s = SW'(b_prr_r) + SS_S;
      end
      flu_pkg::LIM_VANLEER: begin
        if (r_pos) begin
          num_s = rs <<< (F + 1);
          den_s = rs + S_S;
        end
      end
      flu_pkg::LIM_BARTH: begin
        if (rs == -S_S) begin
          fault_nxt = 1'b1;
        end else begin
          num_s = SW'(b_lin_r);
          den_s = D2;
        end
      end
      default: begin
        num_s = '0;
      end
    endcase
  end

  assign num_a = num_s[SW-1] ? -num_s : num_s;
  assign den_a = den_s[SW-1] ? -den_s : den_s;

  logic               c_v_r;
  logic [MB-1:0]      c_num_r, c_den_r;
  flu_pkg::flu_flags_t c_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
    if (en) begin
      c_num_r         <= num_a[MB-1:0];
      c_den_r         <= fault_nxt ? MB'(1) : den_a[MB-1:0];
      c_flags_r.fault <= fault_nxt;
      c_flags_r.neg   <= num_s[SW-1] ^ den_s[SW-1];
    end
  end

  assign out_v     = c_v_r;
  assign out_num   = c_num_r;
  assign out_den   = c_den_r;
  assign out_flags = c_flags_r;

endmodule

[rtl/core/flu_div.sv]
module flu_div #(
  parameter int unsigned WORD_BITS = flu_pkg::WORD_BITS_DEF,
  parameter int unsigned MB        = 2 * flu_pkg::WORD_BITS_DEF + flu_pkg::FRAC_BITS_DEF + 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [MB-1:0]          in_num,
  input  logic [MB-1:0]          in_den,
  input  flu_pkg::flu_flags_t    in_flags,
  output logic                   out_v,
  output logic [WORD_BITS-1:0]   out_quo,
  output logic                   out_ovf,
  output flu_pkg::flu_flags_t    out_flags
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned XW = MB + W;

  logic                v_r   [0:W];
  logic [MB-1:0]       rem_r [0:W];
  logic [MB-1:0]       d_r   [0:W];
  logic [W-1:0]        q_r   [0:W];
  logic                ovf_r [0:W];
  flu_pkg::flu_flags_t fl_r  [0:W];

  logic ovf_nxt;

  // Quotient would need more than W bits: flag for saturation.
  assign ovf_nxt = XW'(in_num) >= (XW'(in_den) << W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      rem_r[0] <= in_num;
      d_r[0]   <= in_den;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_nxt;
      fl_r[0]  <= in_flags;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 1; j <= W; j++) begin : g_step
    localparam int unsigned B = W - j;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] diff;
    logic          take;

    assign dsh   = XW'(d_r[j-1]) << B;
    assign rem_x = XW'(rem_r[j-1]);
    assign diff  = rem_x - dsh;
    assign take  = rem_x >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
      if (en) begin
        rem_r[j] <= take ? diff[MB-1:0] : rem_r[j-1];
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= q_r[j-1] | (take ? (W'(1) << B) : '0);
        ovf_r[j] <= ovf_r[j-1];
        fl_r[j]  <= fl_r[j-1];
      end
    end
  end

  assign out_v     = v_r[W];
  assign out_quo   = q_r[W];
  assign out_ovf   = ovf_r[W];
  assign out_flags = fl_r[W];

endmodule

[rtl/core/flux_limiter_unit.sv]
// Flux limiter unit: phi(r) for a TVD scheme, one ratio per beat.
//
// Input channel: in_valid / in_stall carry in_ratio, a signed fixed-point
// gradient ratio with FRAC_BITS fraction bits. Result channel: out_valid /
// out_stall carry out_limiter_value (same format), out_divide_fault and
// out_saturated. A beat moves when valid is high and stall is low.
// cfg_we with cfg_wdata writes the limiter select (twenty limiters, codes
// 0..19; other codes return 0). Write it only while no beat is in flight.
//
// Pipeline: three front stages (sums, multipliers, operand select), a
// restoring divider of one quotient bit per stage plus an overflow check
// stage, and the output register. Throughput: one beat per cycle while
// out_stall does not hold the pipeline, set by the divider pipeline.
// Reset clears all valid bits and sets the select to donor cell.
// While the output beat waits on out_stall the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.
`include "flux_limiter_unit_defines.svh"

module flux_limiter_unit #(
  parameter int unsigned WORD_BITS = flu_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = flu_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [flu_pkg::SEL_BITS-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [WORD_BITS-1:0]    in_ratio,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [WORD_BITS-1:0]    out_limiter_value,
  output logic                           out_divide_fault,
  output logic                           out_saturated
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned MB = 2 * WORD_BITS + FRAC_BITS + 4;

  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Limiter select register.
  flu_pkg::lim_sel_t sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= flu_pkg::LIM_DONOR;
    end else if (cfg_we) begin
      sel_r <= flu_pkg::lim_sel_t'(cfg_wdata);
    end
  end

  // Advance every stage unless the output beat is blocked.
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic                fr_v;
  logic [MB-1:0]       fr_num, fr_den;
  flu_pkg::flu_flags_t fr_flags;

  flu_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (in_valid),
    .in_ratio  (in_ratio),
    .sel       (sel_r),
    .out_v     (fr_v),
    .out_num   (fr_num),
    .out_den   (fr_den),
    .out_flags (fr_flags)
  );

  logic                div_v;
  logic [W-1:0]        div_q;
  logic                div_ovf;
  flu_pkg::flu_flags_t div_flags;

  flu_div #(
    .WORD_BITS (WORD_BITS),
    .MB        (MB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (fr_v),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_flags  (fr_flags),
    .out_v     (div_v),
    .out_quo   (div_q),
    .out_ovf   (div_ovf),
    .out_flags (div_flags)
  );

  // Apply sign, then clamp to the word range.
  logic [W-1:0] val_nxt;
  logic         sat_nxt;

  always_comb begin
    val_nxt = '0;
    sat_nxt = 1'b0;
    if (div_flags.fault) begin
      val_nxt = '0;
    end else if (!div_flags.neg) begin
      if (div_ovf || div_q[W-1]) begin
        val_nxt = MAX_V;
        sat_nxt = 1'b1;
      end else begin
        val_nxt = div_q;
      end
    end else begin
      if (div_ovf || (div_q > MIN_V)) begin
        val_nxt = MIN_V;
        sat_nxt = 1'b1;
      end else begin
        val_nxt = -div_q;
      end
    end
  end

  logic [W-1:0] val_r;
  logic         fault_r;
  logic         sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v;
    end
    if (en) begin
      val_r   <= val_nxt;
      fault_r <= div_flags.fault;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_limiter_value = val_r;
  assign out_divide_fault  = fault_r;
  assign out_saturated     = sat_r;

  `FLU_ASSERT_IMP(a_fault_zero, out_valid_r && fault_r, (val_r == '0) && !sat_r)
  `FLU_ASSERT_IMP(a_sat_clamp, out_valid_r && sat_r, (val_r == MAX_V) || (val_r == MIN_V))
  `FLU_ASSERT_IMP(a_stall_cause, in_stall, out_valid_r && out_stall)
  `FLU_ASSERT_NXT(a_div_to_out, en && div_v, out_valid_r)

endmodule

[tb/tb_flux_limiter_unit.sv]
`timescale 1ns / 1ps

module tb_flux_limiter_unit;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] value;
    logic               fault;
    logic               sat;
  } phi_t;

  localparam int    HALF_PERIOD = 6;
  localparam wide_t ONE_Q       = 128'sd65536;
  localparam wide_t PHI_HI      = 128'sd2147483647;
  localparam wide_t PHI_LO      = -128'sd2147483648;
  // Roots of 10r^2 + 10r + 1 on the Q16.16 grid, where Ospre blows up.
  localparam int    OSPRE_POLE_A = -7386;
  localparam int    OSPRE_POLE_B = -58150;
  // Idle wait after the drain, with margin over the pipeline depth.
  localparam int    DRAIN_CYCLES = 48;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [flu_pkg::SEL_BITS-1:0]  cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [31:0]            in_ratio;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [31:0]            out_limiter_value;
  logic                          out_divide_fault;
  logic                          out_saturated;

  // Predictor state: the limiter select as last written.
  logic [flu_pkg::SEL_BITS-1:0] active_limiter;
  phi_t                pending_phi[$];
  int                  mismatches   = 0;
  int                  beats_sent   = 0;
  int                  beats_seen   = 0;
  int                  faults_seen  = 0;
  int                  sats_seen    = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;

  flux_limiter_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ratio          (in_ratio),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_limiter_value (out_limiter_value),
    .out_divide_fault  (out_divide_fault),
    .out_saturated     (out_saturated)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic wide_t wmin(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wide_t wmax(wide_t a, wide_t b);
    return (a < b) ? b : a;
  endfunction

  // Exact rational phi(r), truncated toward zero, then saturated.
  function automatic phi_t limiter_phi(logic [flu_pkg::SEL_BITS-1:0] sel,
                                       logic signed [31:0] ratio);
    wide_t r;
    wide_t s;
    wide_t num;
    wide_t den;
    wide_t t;
    wide_t q;
    phi_t  p;
    r   = ratio;
    s   = ONE_Q;
    num = 0;
    den = 1;
    case (sel)
      flu_pkg::LIM_LAXW:  num = s;
      flu_pkg::LIM_BEAMW: num = r;
      flu_pkg::LIM_FROMM: begin
        num = s + r;
        den = 2;
      end
      flu_pkg::LIM_CHARM: begin
        if (r >= 0) begin
          t   = r + s;
          num = r * (3 * r + s) * s;
          den = t * t;
        end
      end
      flu_pkg::LIM_HCUS: begin
        den = r + 2 * s;
        if (r <= 0) begin
          num = 0;
          if (den != 0) den = 1;
        end else begin
          num = 3 * r * s;
        end
      end
      flu_pkg::LIM_HQUICK: begin
        den = r + 3 * s;
        if (r <= 0) begin
          num = 0;
          if (den != 0) den = 1;
        end else begin
          num = 4 * r * s;
        end
      end
      flu_pkg::LIM_KOREN: begin
        num = wmax(0, wmin(24 * r, wmin(4 * (s + 2 * r), 24 * s)));
        den = 12;
      end
      flu_pkg::LIM_MINMOD: num = wmax(0, wmin(r, s));
      flu_pkg::LIM_OSHER: begin
        num = wmax(0, wmin(2 * r, 3 * s));
        den = 2;
      end
      flu_pkg::LIM_OSPRE: begin
        t   = r * r + r * s;
        num = 5 * t * s;
        den = 10 * t + s * s;
      end
      flu_pkg::LIM_SMART: begin
        num = wmax(0, wmin(8 * r, wmin(s + 3 * r, 16 * s)));
        den = 4;
      end
      flu_pkg::LIM_SWEBY: begin
        num = wmax(0, wmax(wmin(3 * r, 2 * s), wmin(2 * r, 3 * s)));
        den = 2;
      end
      flu_pkg::LIM_UMIST: begin
        num = wmax(0, wmin(wmin(8 * r, 3 * s + r), wmin(s + 3 * r, 8 * s)));
        den = 4;
      end
      flu_pkg::LIM_VANALB1: begin
        num = (r * r + r * s) * s;
        den = r * r + s * s;
      end
      flu_pkg::LIM_VANALB2: begin
        num = 2 * r * s * s;
        den = r * r + s * s;
      end
      flu_pkg::LIM_VANLEER: begin
        if (r > 0) begin
          num = 2 * r * s;
          den = s + r;
        end
      end
      flu_pkg::LIM_MC: begin
        num = wmax(0, wmin(4 * s, wmin(s + r, 4 * r)));
        den = 2;
      end
      flu_pkg::LIM_SUPERBEE: num = wmax(0, wmax(wmin(s, 2 * r), wmin(2 * s, r)));
      flu_pkg::LIM_BARTH: begin
        t = r + s;
        if (t == 0) begin
          den = 0;
        end else begin
          num = (t < 0) ? wmax(t, wmax(4 * r, 4 * s)) : wmin(t, wmin(4 * r, 4 * s));
          den = 2;
        end
      end
      default: ;  // donor cell and unused codes: phi stays 0
    endcase
    p.fault = 1'b0;
    p.sat   = 1'b0;
    if (den == 0) begin
      p.fault = 1'b1;
      q       = 0;
    end else begin
      q = num / den;
      if (q > PHI_HI) begin
        q     = PHI_HI;
        p.sat = 1'b1;
      end
      if (q < PHI_LO) begin
        q     = PHI_LO;
        p.sat = 1'b1;
      end
    end
    p.value = q[31:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one ratio beat; returns at the falling edge after acceptance with valid held.
  task automatic send_ratio(logic signed [31:0] ratio);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ratio <= ratio;
    do @(posedge clk); while (in_stall);
    pending_phi.push_back(limiter_phi(active_limiter, ratio));
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid, let the pipeline empty, then let it settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_phi.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limiter(logic [flu_pkg::SEL_BITS-1:0] sel);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(negedge clk);
    cfg_we         <= 1'b0;
    active_limiter  = sel;
  endtask

  // Ratios that hit fault points, saturation, extremes and zero numerators.
  task automatic test_special_points();
    write_limiter(flu_pkg::LIM_HCUS);
    send_ratio(-32'sd131072);
    send_ratio(-32'sd131071);
    send_ratio(32'sd0);
    write_limiter(flu_pkg::LIM_HQUICK);
    send_ratio(-32'sd196608);
    send_ratio(32'sh7fffffff);
    write_limiter(flu_pkg::LIM_BARTH);
    send_ratio(-32'sd65536);
    send_ratio(32'sh80000000);
    send_ratio(32'sh7fffffff);
    write_limiter(flu_pkg::LIM_OSPRE);
    send_ratio(OSPRE_POLE_A);
    send_ratio(OSPRE_POLE_B);
    send_ratio(32'sh80000000);
    write_limiter(flu_pkg::LIM_CHARM);
    send_ratio(-32'sd1);
    send_ratio(32'sh7fffffff);
    write_limiter(flu_pkg::LIM_VANLEER);
    send_ratio(32'sd0);
    send_ratio(32'sd1);
    write_limiter(flu_pkg::LIM_BEAMW);
    send_ratio(32'sh7fffffff);
    send_ratio(32'sh80000000);
    write_limiter(flu_pkg::LIM_LAXW);
    send_ratio(32'sh80000000);
  endtask

  function automatic logic signed [31:0] pick_ratio();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 40) return $signed($urandom_range(8 * 65536)) - 4 * 65536;
    if (kind < 60) return $urandom;
    if (kind < 75) begin
      // near fault points and breakpoints of the piecewise limiters
      case ($urandom_range(5))
        0: return -131072 + $signed($urandom_range(8)) - 4;
        1: return -196608 + $signed($urandom_range(8)) - 4;
        2: return -65536 + $signed($urandom_range(8)) - 4;
        3: return 65536 * $signed($urandom_range(8)) / 2 + $signed($urandom_range(4)) - 2;
        4: return $signed($urandom_range(8)) - 4;
        default: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                          : 32'sh80000000 + $urandom_range(3);
      endcase
    end
    if (kind < 88) begin
      return ($urandom_range(1) ? OSPRE_POLE_A : OSPRE_POLE_B)
             + $signed($urandom_range(400)) - 200;
    end
    return $signed($urandom_range(32'h7fff_ffff)) >>> $urandom_range(30);
  endfunction

  // Walk every select code, unused ones too, under one idling pattern.
  task automatic test_limiter_sweep(int idle_pct, int stall_pct, int per_code);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int code = 0; code < 32; code++) begin
      write_limiter(code[flu_pkg::SEL_BITS-1:0]);
      repeat (per_code) send_ratio(pick_ratio());
    end
  endtask

  // Stall the result side at random; hold steady in no-stall phases.
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    phi_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (out_divide_fault) faults_seen++;
      if (out_saturated) sats_seen++;
      if (pending_phi.size() == 0) begin
        report_mismatch("unexpected beat, limiter_value", out_limiter_value, 0);
      end else begin
        want = pending_phi.pop_front();
        if (out_limiter_value !== want.value)
          report_mismatch("limiter_value", out_limiter_value, want.value);
        if (out_divide_fault !== want.fault)
          report_mismatch("divide_fault", out_divide_fault, want.fault);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_ratio       = '0;
    out_stall      = 1'b0;
    active_limiter = flu_pkg::LIM_DONOR;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset select is donor cell: check it before any write.
    send_ratio(32'sd65536);
    test_special_points();
    test_limiter_sweep(0, 0, 12);
    test_limiter_sweep(64, 0, 12);
    test_limiter_sweep(0, 64, 12);
    test_limiter_sweep(28, 28, 12);
    recv_stall_pct = 0;
    drain_pipeline();

    $display("covered %0d ratio beats over all 32 select codes, %0d results checked",
             beats_sent, beats_seen);
    $display("results with divide fault: %0d, saturated: %0d", faults_seen, sats_seen);
    if (mismatches == 0 && pending_phi.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

[flux_limiter_unit.f]
+incdir+rtl/core
rtl/core/flu_pkg.sv
rtl/core/flu_front.sv
rtl/core/flu_div.sv
rtl/core/flux_limiter_unit.sv
tb/tb_flux_limiter_unit.sv
